// ----- hdl/uer_pkg.sv -----
// Package for the ultrasonic echo ranger: phase codes, configuration
// register indexes, reset values and the structs passed between modules.
// No dependencies.
package uer_pkg;

  // Echo counter width default
  localparam int unsigned CountWidthDef = 16;

  // Fixed field widths
  localparam int unsigned TickW  = 16;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned DistW  = 16;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned CfgIdxW = 3;

  // Fixed-point scale: Q16, rounding half up
  localparam int unsigned FracBits = 16;

  // Configuration reset values
  localparam logic [TickW-1:0]  SettleRst = 16'd2;
  localparam logic [TickW-1:0]  PulseRst  = 16'd10;
  localparam logic [TickW-1:0]  WaitRst   = 16'd30000;
  localparam logic [ScaleW-1:0] ScaleRst  = 24'd121955;
  localparam logic [DistW-1:0]  MaxRst    = 16'd40000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE = 3'd0,
    REG_PULSE  = 3'd1,
    REG_WAIT   = 3'd2,
    REG_SCALE  = 3'd3,
    REG_MAXD   = 3'd4
  } cfg_reg_e;

  // Measurement phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_PULSE  = 5'b00100,
    PH_WAIT   = 5'b01000,
    PH_ECHO   = 5'b10000
  } phase_e;

  // Configuration as seen by the ranging core
  typedef struct packed {
    logic [TickW-1:0]  settle_ticks;
    logic [TickW-1:0]  pulse_ticks;
    logic [TickW-1:0]  wait_limit;
    logic [ScaleW-1:0] scale_q16;
    logic [DistW-1:0]  dist_limit;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic             trig;
    logic             busy_res;
    logic             done_res;
    logic             timed_out;
    logic [DistW-1:0] distance;
  } res_t;

endpackage

// ----- hdl/uer_scale.sv -----
// Echo count to distance: count * scale in Q16, rounded, clamped to max.
// Depends on uer_pkg.
module uer_scale import uer_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [ScaleW-1:0]      scale_i,
  input  logic [DistW-1:0]       max_i,
  output logic [DistW-1:0]       dist_o
);

  localparam int unsigned ProdW = COUNT_WIDTH + ScaleW + 1;
  localparam int unsigned ShW   = ProdW - FracBits;

  logic [ProdW-1:0] prod;
  logic [ShW-1:0]   whole;

  // Product plus half an LSB of the result, then drop the fraction
  assign prod  = ProdW'(count_i) * ProdW'(scale_i)
               + (ProdW'(1) << (FracBits - 1));
  assign whole = prod[ProdW-1:FracBits];

  // Clamp to the maximum distance
  assign dist_o = (whole > ShW'(max_i)) ? max_i : whole[DistW-1:0];

endmodule

// ----- hdl/uer_core.sv -----
// Ranging sequencer: trigger timing, echo edge detection, counting and
// timeout. One step per accepted word. Depends on uer_pkg and uer_scale.
module uer_core import uer_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic start_req_i,
  input  logic echo_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [TickW-1:0]       WaitSat  = '1;

  phase_e                 phase_q, phase_d;
  logic [TickW-1:0]       pcnt_q, pcnt_d;
  logic [TickW-1:0]       wcnt_q, wcnt_d;
  logic [COUNT_WIDTH-1:0] ecnt_q, ecnt_d;
  logic                   eprev_q;
  logic [DistW-1:0]       dist_q, dist_d;
  logic                   tout_q, tout_d;
  logic                   done;
  logic [TickW-1:0]       plen;
  logic [TickW-1:0]       wait_inc;
  logic [DistW-1:0]       scaled;

  uer_scale #(.COUNT_WIDTH(COUNT_WIDTH)) u_scale (
    .count_i (ecnt_q),
    .scale_i (cfg_i.scale_q16),
    .max_i   (cfg_i.dist_limit),
    .dist_o  (scaled)
  );

  // Pulse length of zero acts as one; wait counter saturates
  assign plen     = (cfg_i.pulse_ticks == '0) ? TickW'(1) : cfg_i.pulse_ticks;
  assign wait_inc = (wcnt_q < WaitSat) ? wcnt_q + TickW'(1) : wcnt_q;

  // Next state
  always_comb begin
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    wcnt_d  = wcnt_q;
    ecnt_d  = ecnt_q;
    dist_d  = dist_q;
    tout_d  = tout_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_SETTLE: begin
        if (pcnt_q >= cfg_i.settle_ticks) begin
          phase_d = PH_PULSE;
          pcnt_d  = TickW'(1);
        end else begin
          pcnt_d = pcnt_q + TickW'(1);
        end
      end
      PH_PULSE: begin
        if (pcnt_q >= plen) begin
          phase_d = PH_WAIT;
          wcnt_d  = '0;
          ecnt_d  = '0;
        end else begin
          pcnt_d = pcnt_q + TickW'(1);
        end
      end
      PH_WAIT: begin
        wcnt_d = wait_inc;
        if (echo_i && !eprev_q) begin
          phase_d = PH_ECHO;
          ecnt_d  = COUNT_WIDTH'(1);
        end else if (wait_inc >= cfg_i.wait_limit) begin
          phase_d = PH_IDLE;
          tout_d  = 1'b1;
          dist_d  = cfg_i.dist_limit;
          done    = 1'b1;
        end
      end
      PH_ECHO: begin
        wcnt_d = wait_inc;
        if (!echo_i) begin
          // falling edge wins over the wait limit
          phase_d = PH_IDLE;
          tout_d  = 1'b0;
          dist_d  = scaled;
          done    = 1'b1;
        end else if (ecnt_q == CountMax) begin
          phase_d = PH_IDLE;
          tout_d  = 1'b1;
          dist_d  = cfg_i.dist_limit;
          done    = 1'b1;
        end else begin
          ecnt_d = ecnt_q + COUNT_WIDTH'(1);
          if (wait_inc >= cfg_i.wait_limit) begin
            phase_d = PH_IDLE;
            tout_d  = 1'b1;
            dist_d  = cfg_i.dist_limit;
            done    = 1'b1;
          end
        end
      end
      default: begin
        // idle, and any stray code
        phase_d = PH_IDLE;
        if (start_req_i) begin
          pcnt_d  = TickW'(1);
          phase_d = (cfg_i.settle_ticks == '0) ? PH_PULSE : PH_SETTLE;
        end
      end
    endcase
  end

  // State registers, stepped once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pcnt_q  <= '0;
      wcnt_q  <= '0;
      ecnt_q  <= '0;
      eprev_q <= 1'b0;
      dist_q  <= '0;
      tout_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pcnt_q  <= pcnt_d;
      wcnt_q  <= wcnt_d;
      ecnt_q  <= ecnt_d;
      eprev_q <= echo_i;
      dist_q  <= dist_d;
      tout_q  <= tout_d;
    end
  end

  // Result reflects the state after this step
  assign res_o.trig      = (phase_d == PH_PULSE);
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.timed_out = tout_d;
  assign res_o.distance  = dist_d;

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger top level: configuration registers, input and
// result registers around the ranging core. Depends on uer_pkg, uer_core.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------
//  input    | in_valid_i / in_stall_o      | start_req_i, echo_i
//  result   | out_valid_o / out_stall_i    | trig_o, busy_res_o, done_res_o,
//           |                              | timed_out_o, distance_o
//  config   | cfg_we_i, cfg_idx_i          | cfg_wdata_i
//
// Each word passes through the input register, then the result register;
// one word per cycle is sustained while out_stall_i stays low. The step
// of the core (compare, one 16x24 multiply at the default count width,
// clamp) fits between the two.
// Reset clears control state and loads the configuration defaults.
// A stalled result holds; the input register still takes a word until it
// too is full, and in_stall_o rises only then.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               start_req_i,
  input  logic               echo_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               trig_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               timed_out_o,
  output logic [DistW-1:0]   distance_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t cfg_q;
  logic in_valid_q;
  logic start_q, echo_q;
  logic out_valid_q;
  res_t res_q, res_d;
  logic advance, take_in;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks <= SettleRst;
      cfg_q.pulse_ticks  <= PulseRst;
      cfg_q.wait_limit   <= WaitRst;
      cfg_q.scale_q16    <= ScaleRst;
      cfg_q.dist_limit   <= MaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SETTLE: cfg_q.settle_ticks <= cfg_wdata_i[TickW-1:0];
        REG_PULSE:  cfg_q.pulse_ticks  <= cfg_wdata_i[TickW-1:0];
        REG_WAIT:   cfg_q.wait_limit   <= cfg_wdata_i[TickW-1:0];
        REG_SCALE:  cfg_q.scale_q16    <= cfg_wdata_i[ScaleW-1:0];
        REG_MAXD:   cfg_q.dist_limit   <= cfg_wdata_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input word moves on when the result slot frees
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      start_q <= start_req_i;
      echo_q  <= echo_i;
    end
  end

  uer_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q && advance),
    .start_req_i (start_q),
    .echo_i      (echo_q),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign trig_o      = res_q.trig;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign timed_out_o = res_q.timed_out;
  assign distance_o  = res_q.distance;

endmodule

// ----- hdl/uer_checker.sv -----
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg.
module uer_checker import uer_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             trig_o,
  input logic             busy_res_o,
  input logic             done_res_o,
  input logic [DistW-1:0] distance_o
);

  // A stalled result word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Trigger only driven during a measurement
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trig_o |-> busy_res_o)
    else $error("trigger high while not busy");

  // A finished measurement leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !trig_o)
    else $error("done reported while still busy");

  // Distance only changes on a word that reports done
  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && !done_res_o
      |-> distance_o == $past(distance_o))
    else $error("distance changed without done");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .trig_o      (trig_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .distance_o  (distance_o)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for ultrasonic_echo_ranger: a tick-by-tick ranging predictor checks every
// result word. Directed and most random phases run with random idling and stalls.
// Depends on uer_pkg and the ranger RTL.
module tb;
  import uer_pkg::*;

  localparam int unsigned CountW     = CountWidthDef;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandWords  = 900;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               start_req_i = 1'b0;
  logic               echo_i      = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               trig_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic               timed_out_o;
  logic [DistW-1:0]   distance_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  // Ranging state as the block should hold it
  cfg_t              rg_cfg;
  phase_e            rg_phase;
  logic [TickW-1:0]  rg_phase_cnt;
  logic [TickW-1:0]  rg_wait_cnt;
  logic [CountW-1:0] rg_echo_cnt;
  logic              rg_echo_prev;
  logic              rg_timeout;
  logic [DistW-1:0]  rg_dist;

  res_t        ranger_words[$];
  int unsigned n_fail;
  int unsigned sent_words;
  int unsigned quiet;
  bit          calm;

  ultrasonic_echo_ranger #(.COUNT_WIDTH(CountW)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_req_i (start_req_i),
    .echo_i      (echo_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .trig_o      (trig_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .timed_out_o (timed_out_o),
    .distance_o  (distance_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void ranger_reset();
    rg_cfg       = '{SettleRst, PulseRst, WaitRst, ScaleRst, MaxRst};
    rg_phase     = PH_IDLE;
    rg_phase_cnt = '0;
    rg_wait_cnt  = '0;
    rg_echo_cnt  = '0;
    rg_echo_prev = 1'b0;
    rg_timeout   = 1'b0;
    rg_dist      = '0;
  endfunction

  // Echo width to hundredths of cm, Q16 rounding half up, clamped
  function automatic logic [DistW-1:0] echo_to_dist(logic [CountW-1:0] cnt);
    logic [63:0] d;
    d = (64'(cnt) * 64'(rg_cfg.scale_q16) + 64'd32768) >> FracBits;
    if (d > 64'(rg_cfg.dist_limit)) d = 64'(rg_cfg.dist_limit);
    return d[DistW-1:0];
  endfunction

  function automatic void ranger_finish(logic to, logic [DistW-1:0] result_dist);
    rg_timeout = to;
    rg_dist    = result_dist;
    rg_phase   = PH_IDLE;
  endfunction

  // One timebase tick: advance the ranging state, return the result word
  function automatic res_t ranger_step(logic start, logic echo);
    res_t             r;
    logic             done;
    logic [TickW-1:0] plen;
    done = 1'b0;
    plen = (rg_cfg.pulse_ticks == '0) ? TickW'(1) : rg_cfg.pulse_ticks;
    case (rg_phase)
      PH_SETTLE: begin
        if (rg_phase_cnt >= rg_cfg.settle_ticks) begin
          rg_phase     = PH_PULSE;
          rg_phase_cnt = TickW'(1);
        end else begin
          rg_phase_cnt++;
        end
      end
      PH_PULSE: begin
        if (rg_phase_cnt >= plen) begin
          rg_phase    = PH_WAIT;
          rg_wait_cnt = '0;
          rg_echo_cnt = '0;
        end else begin
          rg_phase_cnt++;
        end
      end
      PH_WAIT: begin
        if (rg_wait_cnt != '1) rg_wait_cnt++;
        // rising edge beats the wait limit
        if (echo && !rg_echo_prev) begin
          rg_phase    = PH_ECHO;
          rg_echo_cnt = CountW'(1);
        end else if (rg_wait_cnt >= rg_cfg.wait_limit) begin
          ranger_finish(1'b1, rg_cfg.dist_limit);
          done = 1'b1;
        end
      end
      PH_ECHO: begin
        if (rg_wait_cnt != '1) rg_wait_cnt++;
        if (!echo) begin
          ranger_finish(1'b0, echo_to_dist(rg_echo_cnt));
          done = 1'b1;
        end else if (&rg_echo_cnt) begin
          ranger_finish(1'b1, rg_cfg.dist_limit);
          done = 1'b1;
        end else begin
          rg_echo_cnt++;
          if (rg_wait_cnt >= rg_cfg.wait_limit) begin
            ranger_finish(1'b1, rg_cfg.dist_limit);
            done = 1'b1;
          end
        end
      end
      default: begin
        rg_phase = PH_IDLE;
        if (start) begin
          rg_phase     = (rg_cfg.settle_ticks == '0) ? PH_PULSE : PH_SETTLE;
          rg_phase_cnt = TickW'(1);
        end
      end
    endcase
    rg_echo_prev = echo;
    r.trig      = (rg_phase == PH_PULSE);
    r.busy_res  = (rg_phase != PH_IDLE);
    r.done_res  = done;
    r.timed_out = rg_timeout;
    r.distance  = rg_dist;
    return r;
  endfunction

  function automatic cfg_t make_cfg(int unsigned settle, int unsigned pulse,
                                    int unsigned wlim, int unsigned scale,
                                    int unsigned maxd);
    cfg_t c;
    c.settle_ticks = TickW'(settle);
    c.pulse_ticks  = TickW'(pulse);
    c.wait_limit   = TickW'(wlim);
    c.scale_q16    = ScaleW'(scale);
    c.dist_limit   = DistW'(maxd);
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    int unsigned scale;
    int unsigned maxd;
    case ($urandom_range(3))
      0:       scale = 0;
      1:       scale = 24'hFFFFFF;
      2:       scale = $urandom & 24'hFFFFFF;
      default: scale = $urandom_range(20000, 200000);
    endcase
    case ($urandom_range(3))
      0:       maxd = 0;
      1:       maxd = 16'hFFFF;
      default: maxd = $urandom & 16'hFFFF;
    endcase
    return make_cfg($urandom_range(0, 4), $urandom_range(1, 4),
                    ($urandom_range(3) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40),
                    scale, maxd);
  endfunction

  // Send one tick word; the expectation is formed when it is taken
  task automatic send_word(input logic start, input logic echo);
    res_t r;
    if (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start;
    echo_i      <= echo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = ranger_step(start, echo);
    ranger_words.push_back(r);
    sent_words++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic start, input logic echo, input int unsigned n);
    repeat (n) send_word(start, echo);
  endtask

  // Hold the sender off until every pending word is out, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (ranger_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_reg_e order[5] = '{REG_SETTLE, REG_PULSE, REG_WAIT, REG_SCALE, REG_MAXD};
    logic [CfgW-1:0] data;
    drain_results();
    for (int i = 0; i < 5; i++) begin
      case (order[i])
        REG_SETTLE: data = CfgW'(c.settle_ticks);
        REG_PULSE:  data = CfgW'(c.pulse_ticks);
        REG_WAIT:   data = CfgW'(c.wait_limit);
        REG_SCALE:  data = CfgW'(c.scale_q16);
        default:    data = CfgW'(c.dist_limit);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= order[i];
      cfg_wdata_i <= data;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    rg_cfg = c;
  endtask

  // One measurement from idle; echo high over [lead, lead+len) ticks after the start
  task automatic measure(input int unsigned lead, input int unsigned len, input bit noisy);
    int unsigned k;
    k = 0;
    send_word(1'b1, noisy ? 1'($urandom_range(1)) : (lead == 0 && len != 0));
    k = 1;
    while (rg_phase != PH_IDLE) begin
      if ($urandom_range(199) == 0) drain_results();
      send_word($urandom_range(9) == 0,
                noisy ? 1'($urandom_range(1)) : (k >= lead && k < lead + len));
      k++;
    end
  endtask

  // Long wait limits only get echoes that start once the edge is looked for
  task automatic measure_random();
    int unsigned pre;
    int unsigned span;
    int unsigned mode;
    int unsigned lo;
    pre  = rg_cfg.settle_ticks + ((rg_cfg.pulse_ticks == '0) ? 1 : rg_cfg.pulse_ticks) + 1;
    span = (rg_cfg.wait_limit < 40) ? rg_cfg.wait_limit + 3 : 40;
    lo   = (rg_cfg.wait_limit > 300) ? pre : 0;
    mode = $urandom_range(9);
    if (mode == 0 && rg_cfg.wait_limit <= 300) measure(0, 0, 1'b0);
    else if (mode == 1) measure(0, 0, 1'b1);
    else measure($urandom_range(lo, pre + span), $urandom_range(1, 40), 1'b0);
  endtask

  // Short echo pulses close any open measurement quickly
  task automatic settle_to_idle();
    logic lvl;
    lvl = 1'b0;
    while (rg_phase != PH_IDLE) begin
      send_word(1'b0, lvl);
      lvl = !lvl;
    end
  endtask

  // Edge detection only after the pulse; start while busy is ignored
  task automatic test_edge_detect();
    load_config(make_cfg(0, 1, 20, 65536, 65535));
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b1);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
  endtask

  // Non-zero settle, zero pulse length, rounding of a 1.5 scale
  task automatic test_zero_pulse_settle();
    load_config(make_cfg(3, 0, 20, 98304, 65535));
    send_word(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 4);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
  endtask

  task automatic test_timeouts();
    // zero wait limit gives up on the first waiting tick
    load_config(make_cfg(0, 1, 0, 65536, 1234));
    send_run(1'b0, 1'b0, 1);
    send_word(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 2);
    // limit reached while echo still high
    load_config(make_cfg(0, 1, 3, 65536, 65535));
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_run(1'b0, 1'b1, 3);
    // falling edge on the limit tick wins
    send_word(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 2);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    // rising edge on the limit tick wins too
    send_word(1'b1, 1'b0);
    send_run(1'b0, 1'b0, 3);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
  endtask

  task automatic test_clamp();
    load_config(make_cfg(0, 1, 10, 24'hFFFFFF, 100));
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
  endtask

  // Long counts: long settle, pulse and wait, then a long echo under the top wait limit
  task automatic test_long_extremes();
    calm = 1'b1;
    load_config(make_cfg(100, 80, 120, 16, 65535));
    measure(0, 0, 1'b0);
    load_config(make_cfg(0, 0, 65535, 65536, 65535));
    measure(2, 150, 1'b0);
    calm = 1'b0;
  endtask

  task automatic test_random_ranging();
    int unsigned base;
    int unsigned ph;
    base = sent_words;
    ph   = 0;
    while (sent_words - base < RandWords) begin
      load_config(ph == 0 ? make_cfg(SettleRst, PulseRst, WaitRst, ScaleRst, MaxRst)
                          : random_cfg());
      calm = (ph == 2);
      repeat (8) measure_random();
      // noise: random starts and echo levels
      repeat (12) send_word($urandom_range(7) == 0, 1'($urandom_range(1)));
      settle_to_idle();
      ph++;
    end
    calm = 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 26);

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each result word with the oldest pending one
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ranger_words.size() == 0) begin
        n_fail++;
        $display("%0t: result word with nothing pending", $time);
      end else begin
        want = ranger_words.pop_front();
        check_field("trig", want.trig, trig_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("timed_out", want.timed_out, timed_out_o);
        check_field("distance", want.distance, distance_o);
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    n_fail     = 0;
    sent_words = 0;
    quiet      = 0;
    calm       = 1'b0;
    ranger_reset();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edge_detect();
    test_zero_pulse_settle();
    test_timeouts();
    test_clamp();
    test_long_extremes();
    test_random_ranging();
    drain_results();
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/uer_pkg.sv
hdl/uer_scale.sv
hdl/uer_core.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
tb/sv/tb.sv
